[sv/b64d_pkg.sv]
// b64d_pkg: shared types, constants and the character classifier for the
// base64 stream decoder. No dependencies.
package b64d_pkg;

   // Status codes carried on each result word
   typedef enum logic [1:0] {
      STAT_OK        = 2'd0,
      STAT_BAD_CHAR  = 2'd1,
      STAT_BAD_LEN   = 2'd2,
      STAT_AFTER_END = 2'd3
   } status_type;

   // Position of a character within its group of four
   localparam logic [1:0] SLOT_FIRST  = 2'd0;
   localparam logic [1:0] SLOT_SECOND = 2'd1;
   localparam logic [1:0] SLOT_THIRD  = 2'd2;
   localparam logic [1:0] SLOT_FOURTH = 2'd3;

   localparam logic [7:0] PAD_CHAR = 8'h3D;   // '='

   // Default depth of the queue between front and back
   localparam int QUEUE_DEPTH_DEFAULT = 2;

   // One classified character as passed from front to back
   typedef struct packed {
      logic       last;
      logic       is_pad;
      logic       is_valid;
      logic [5:0] sextet;
   } chr_item_type;

   // Map a raw character to its sextet; is_valid low when outside the alphabet
   function automatic chr_item_type classify(input logic [7:0] ch, input logic last);
      chr_item_type item;
      item.last     = last;
      item.is_pad   = (ch == PAD_CHAR);
      item.is_valid = 1'b1;
      item.sextet   = 6'd0;
      if (ch >= 8'h41 && ch <= 8'h5A) begin
         item.sextet = 6'(ch - 8'h41);
      end else if (ch >= 8'h61 && ch <= 8'h7A) begin
         item.sextet = 6'(ch - 8'h61 + 8'd26);
      end else if (ch >= 8'h30 && ch <= 8'h39) begin
         item.sextet = 6'(ch - 8'h30 + 8'd52);
      end else if (ch == 8'h2B) begin
         item.sextet = 6'd62;
      end else if (ch == 8'h2F) begin
         item.sextet = 6'd63;
      end else begin
         item.is_valid = 1'b0;
      end
      return item;
   endfunction

endpackage

[sv/b64d_front.sv]
// b64d_front: accepts input words, classifies each character and holds the
// result in a short queue for the back end. Depends on b64d_pkg.
module b64d_front #(
   parameter int QUEUE_DEPTH = b64d_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   output logic                  full,
   input  logic [7:0]            in_char,
   input  logic                  last_char,
   output logic                  head_valid,
   output b64d_pkg::chr_item_type head_item,
   input  logic                  head_take
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   b64d_pkg::chr_item_type mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full       = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_item  = mem_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = head_take && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= b64d_pkg::classify(in_char, last_char);
      end
   end

endmodule

[sv/b64d_back.sv]
// b64d_back: group sequencing, byte assembly, error tracking and the result
// register. Depends on b64d_pkg.
module b64d_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   head_valid,
   input  b64d_pkg::chr_item_type head_item,
   output logic                   head_take,
   output logic                   empty,
   input  logic                   pop,
   output logic [7:0]             out_byte,
   output logic                   byte_valid,
   output logic                   string_end,
   output logic [1:0]             status
);

   logic [1:0]           slot_ff, slot_in;
   logic [5:0]           held_ff, held_in;
   logic                 term_ff, term_in;
   logic                 pad3_ff, pad3_in;
   b64d_pkg::status_type err_ff, err_in, err_cur, stat_w;

   logic                 out_valid_ff;
   logic [7:0]           out_byte_ff;
   logic                 byte_valid_ff;
   logic                 string_end_ff;
   b64d_pkg::status_type status_ff;

   logic [7:0]           byte_w;
   logic                 have_w;
   logic                 step;

   // advance when a character waits and the result slot is free or draining
   assign step      = head_valid && (!out_valid_ff || pop);
   assign head_take = step;

   always_comb begin
      slot_in = slot_ff + 2'd1;
      held_in = held_ff;
      term_in = term_ff;
      pad3_in = pad3_ff;
      byte_w  = 8'd0;
      have_w  = 1'b0;
      err_cur = (err_ff == b64d_pkg::STAT_OK && term_ff) ? b64d_pkg::STAT_AFTER_END : err_ff;
      err_in  = err_cur;

      if (err_cur == b64d_pkg::STAT_OK) begin
         case (slot_ff)
            b64d_pkg::SLOT_FIRST: begin
               if (!head_item.is_valid) err_in = b64d_pkg::STAT_BAD_CHAR;
               else held_in = head_item.sextet;
            end
            b64d_pkg::SLOT_SECOND: begin
               if (!head_item.is_valid) begin
                  err_in = b64d_pkg::STAT_BAD_CHAR;
               end else begin
                  byte_w  = {held_ff, head_item.sextet[5:4]};
                  have_w  = 1'b1;
                  held_in = head_item.sextet;
               end
            end
            b64d_pkg::SLOT_THIRD: begin
               if (head_item.is_pad) begin
                  pad3_in = 1'b1;
               end else if (!head_item.is_valid) begin
                  err_in = b64d_pkg::STAT_BAD_CHAR;
               end else begin
                  byte_w  = {held_ff[3:0], head_item.sextet[5:2]};
                  have_w  = 1'b1;
                  held_in = head_item.sextet;
               end
            end
            default: begin
               if (pad3_ff || head_item.is_pad) begin
                  term_in = 1'b1;
               end else if (!head_item.is_valid) begin
                  err_in = b64d_pkg::STAT_BAD_CHAR;
               end else begin
                  byte_w  = {held_ff[1:0], head_item.sextet};
                  have_w  = 1'b1;
                  held_in = head_item.sextet;
               end
            end
         endcase
      end

      if (slot_ff == b64d_pkg::SLOT_FOURTH) pad3_in = 1'b0;

      stat_w = (head_item.last && slot_ff != b64d_pkg::SLOT_FOURTH)
               ? b64d_pkg::STAT_BAD_LEN : err_in;
      if (stat_w != b64d_pkg::STAT_OK) begin
         have_w = 1'b0;
         byte_w = 8'd0;
      end

      // string done: back to reset values
      if (head_item.last) begin
         slot_in = b64d_pkg::SLOT_FIRST;
         held_in = 6'd0;
         term_in = 1'b0;
         pad3_in = 1'b0;
         err_in  = b64d_pkg::STAT_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff      <= b64d_pkg::SLOT_FIRST;
         held_ff      <= 6'd0;
         term_ff      <= 1'b0;
         pad3_ff      <= 1'b0;
         err_ff       <= b64d_pkg::STAT_OK;
         out_valid_ff <= 1'b0;
      end else begin
         if (step) begin
            slot_ff      <= slot_in;
            held_ff      <= held_in;
            term_ff      <= term_in;
            pad3_ff      <= pad3_in;
            err_ff       <= err_in;
            out_valid_ff <= 1'b1;
         end else if (pop && out_valid_ff) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         out_byte_ff   <= byte_w;
         byte_valid_ff <= have_w;
         string_end_ff <= head_item.last;
         status_ff     <= stat_w;
      end
   end

   assign empty      = !out_valid_ff;
   assign out_byte   = out_byte_ff;
   assign byte_valid = byte_valid_ff;
   assign string_end = string_end_ff;
   assign status     = status_ff;

`ifndef SYNTH
   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      step && head_item.last |=> slot_ff == b64d_pkg::SLOT_FIRST
         && err_ff == b64d_pkg::STAT_OK && !term_ff && !pad3_ff)
      else $error("state not cleared after last word");
   a_pad3_slot: assert property (@(posedge clock) disable iff (reset)
      pad3_ff |-> slot_ff == b64d_pkg::SLOT_FOURTH)
      else $error("third-slot pad mark outside fourth slot");
   a_term_slot: assert property (@(posedge clock) disable iff (reset)
      term_ff |-> slot_ff == b64d_pkg::SLOT_FIRST || err_ff != b64d_pkg::STAT_OK)
      else $error("terminated group left mid-group without error");
   a_byte_ok: assert property (@(posedge clock) disable iff (reset)
      step |=> !byte_valid_ff || status_ff == b64d_pkg::STAT_OK)
      else $error("byte given alongside an error status");
`endif

endmodule

[sv/base64_stream_decoder.sv]
// base64_stream_decoder: top level of the streaming base64 decoder.
// Depends on b64d_pkg, b64d_front and b64d_back.
//
// Decodes base64 text (standard alphabet, '=' padding) one character per
// word and returns exactly one result word per character. Each result
// carries a decoded byte when the character completed one (second, third
// and fourth characters of a group), a string-end flag echoing the last
// character mark, and a status: ok, invalid character, bad length or data
// after terminator. The first error is sticky for the rest of the string
// and suppresses bytes; a bad length, seen only on the last character,
// overrides it. All state clears after the last character. Throughput is
// one character per clock while results are popped: the front classifies each character into a
// short queue and the back assembles bytes into a result register, so a
// new character is taken while a finished result still waits to be popped.
// A taken character passes through the queue and then the result register
// before its result shows on the output ports. No clearing pass after reset.
module base64_stream_decoder #(
   parameter int QUEUE_DEPTH = b64d_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   // input channel
   input  logic       push,
   output logic       full,
   input  logic [7:0] req_in_char,
   input  logic       req_last_char,
   // result channel
   output logic       empty,
   input  logic       pop,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_byte_valid,
   output logic       rsp_string_end,
   output logic [1:0] rsp_status
);

   logic                   head_valid;
   logic                   head_take;
   b64d_pkg::chr_item_type head_item;

   // front: accept and classify, queued towards the back
   b64d_front #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .full       (full),
      .in_char    (req_in_char),
      .last_char  (req_last_char),
      .head_valid (head_valid),
      .head_item  (head_item),
      .head_take  (head_take)
   );

   // back: group tracking, byte assembly, status and result register
   b64d_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_item  (head_item),
      .head_take  (head_take),
      .empty      (empty),
      .pop        (pop),
      .out_byte   (rsp_out_byte),
      .byte_valid (rsp_byte_valid),
      .string_end (rsp_string_end),
      .status     (rsp_status)
   );

endmodule

[verif/base64_stream_decoder_tb.sv]
// base64_stream_decoder_tb: self-checking testbench for the base64 stream decoder.
// Depends on b64d_pkg (status codes, slot names, pad character) and base64_stream_decoder.
// Checks every result word against a predictor kept in step with accepted characters.
module base64_stream_decoder_tb;

   // Generous cycle budget: under 1000 characters, each behind random gaps
   // and receiver stalls, stay well within the limit.
   localparam int CYCLE_LIMIT  = 200000;
   localparam int RANDOM_CHARS = 800;
   localparam int DRAIN_CYCLES = 8;    // wait for stray words after the last expected one, with margin
   localparam int REPORT_MAX   = 10;

   // One expected or observed result word
   typedef struct packed {
      logic [7:0]           data_byte;
      logic                 has_byte;
      logic                 str_end;
      b64d_pkg::status_type stat;
   } dec_word_type;

   logic       clock;
   logic       reset;
   logic       push;
   logic       full;
   logic [7:0] req_in_char;
   logic       req_last_char;
   logic       empty;
   logic       pop;
   logic [7:0] rsp_out_byte;
   logic       rsp_byte_valid;
   logic       rsp_string_end;
   logic [1:0] rsp_status;

   base64_stream_decoder u_dut (
      .clock          (clock),
      .reset          (reset),
      .push           (push),
      .full           (full),
      .req_in_char    (req_in_char),
      .req_last_char  (req_last_char),
      .empty          (empty),
      .pop            (pop),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_byte_valid (rsp_byte_valid),
      .rsp_string_end (rsp_string_end),
      .rsp_status     (rsp_status)
   );

   // Clock: period of 2 time units
   initial clock = 1'b0;
   always #1 clock = ~clock;

   // ------------------------------------------------------------------
   // Decoder model: lookup tables built from the alphabet, plus its own
   // copy of the group position, held sextet, terminator and error state.
   // ------------------------------------------------------------------
   string      b64_alphabet =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
   logic [5:0] sextet_tab  [256];
   logic       in_alphabet [256];

   logic [1:0]           slot_pos;
   logic [5:0]           held;
   logic                 term_seen;
   logic                 pad_third;
   b64d_pkg::status_type err_code;

   dec_word_type owed_words[$];   // results still due, oldest first
   int         accept_count;
   int         chars_sent;
   int         mismatch_count;
   int         cycle_count;
   int         burst_left;
   logic [7:0] text_buf[$];       // string being assembled for sending

   // Receiver stall pattern
   int         stall_mode;
   int         pop_tick;

   // Work out the result word for one accepted character and advance state
   function automatic dec_word_type decode_char(input logic [7:0] ch, input logic fin);
      dec_word_type w;
      logic [1:0]   slot;
      logic         ok_char;
      logic [5:0]   v;
      slot        = slot_pos;
      ok_char     = in_alphabet[ch];
      v           = sextet_tab[ch];
      w.data_byte = 8'h00;
      w.has_byte  = 1'b0;
      w.str_end   = fin;

      // anything after a padded group is an error, first error sticks
      if (err_code == b64d_pkg::STAT_OK && term_seen) begin
         err_code = b64d_pkg::STAT_AFTER_END;
      end

      if (err_code == b64d_pkg::STAT_OK) begin
         case (slot)
            b64d_pkg::SLOT_FIRST: begin
               if (!ok_char) err_code = b64d_pkg::STAT_BAD_CHAR;
               else held = v;
            end
            b64d_pkg::SLOT_SECOND: begin
               if (!ok_char) begin
                  err_code = b64d_pkg::STAT_BAD_CHAR;
               end else begin
                  w.data_byte = {held, v[5:4]};
                  w.has_byte  = 1'b1;
                  held        = v;
               end
            end
            b64d_pkg::SLOT_THIRD: begin
               if (ch == b64d_pkg::PAD_CHAR) begin
                  pad_third = 1'b1;
               end else if (!ok_char) begin
                  err_code = b64d_pkg::STAT_BAD_CHAR;
               end else begin
                  w.data_byte = {held[3:0], v[5:2]};
                  w.has_byte  = 1'b1;
                  held        = v;
               end
            end
            default: begin
               // after '=' in the third slot the fourth is not looked at
               if (pad_third || ch == b64d_pkg::PAD_CHAR) begin
                  term_seen = 1'b1;
               end else if (!ok_char) begin
                  err_code = b64d_pkg::STAT_BAD_CHAR;
               end else begin
                  w.data_byte = {held[1:0], v};
                  w.has_byte  = 1'b1;
                  held        = v;
               end
            end
         endcase
      end

      if (slot == b64d_pkg::SLOT_FOURTH) pad_third = 1'b0;
      slot_pos = slot + 2'd1;

      // bad length is only known on the last character and beats all else
      w.stat = err_code;
      if (fin && slot != b64d_pkg::SLOT_FOURTH) w.stat = b64d_pkg::STAT_BAD_LEN;
      if (w.stat != b64d_pkg::STAT_OK) begin
         w.has_byte  = 1'b0;
         w.data_byte = 8'h00;
      end

      if (fin) begin
         slot_pos  = b64d_pkg::SLOT_FIRST;
         held      = 6'd0;
         term_seen = 1'b0;
         pad_third = 1'b0;
         err_code  = b64d_pkg::STAT_OK;
      end
      return w;
   endfunction

   // Accepted characters feed the model
   always @(posedge clock) begin
      if (!reset && push && !full) begin
         owed_words.push_back(decode_char(req_in_char, req_last_char));
         accept_count++;
      end
   end

   // Result checker: each popped word against the oldest expectation
   always @(posedge clock) begin
      dec_word_type got;
      dec_word_type exp_w;
      if (!reset && pop && !empty) begin
         got.data_byte = rsp_out_byte;
         got.has_byte  = rsp_byte_valid;
         got.str_end   = rsp_string_end;
         got.stat      = b64d_pkg::status_type'(rsp_status);
         if (owed_words.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_MAX)
               $display("tb: unexpected word byte=%h valid=%b end=%b status=%0d",
                        got.data_byte, got.has_byte, got.str_end, got.stat);
         end else begin
            exp_w = owed_words.pop_front();
            if (got.data_byte !== exp_w.data_byte || got.has_byte !== exp_w.has_byte ||
                got.str_end !== exp_w.str_end || got.stat !== exp_w.stat) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_MAX)
                  $display({"tb: mismatch exp byte=%h valid=%b end=%b status=%0d",
                            " got byte=%h valid=%b end=%b status=%0d"},
                           exp_w.data_byte, exp_w.has_byte, exp_w.str_end, exp_w.stat,
                           got.data_byte, got.has_byte, got.str_end, got.stat);
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // Receiver: pop on a randomly chosen pattern -- always ready, coin
   // toss, long stalls, or ready half the time in a repeating window.
   always @(negedge clock) begin
      pop_tick++;
      if (pop_tick % 96 == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
         0:       pop = 1'b1;
         1:       pop = 1'($urandom_range(0, 1));
         2:       pop = (pop_tick % 5 == 0);
         default: pop = (pop_tick % 16 < 8);
      endcase
   end

   // ------------------------------------------------------------------
   // Sender. Called at a falling edge, returns at the falling edge after
   // the word has been taken, with push still high; bursts of random
   // length are separated by random gaps.
   // ------------------------------------------------------------------
   task automatic send_char(input logic [7:0] ch, input logic fin);
      int n;
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(1, 8);
         push = 1'b0;
         repeat (gap) @(negedge clock);
         // now and then a long stretch with no gaps at all
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80)
                                                  : $urandom_range(1, 12);
      end
      burst_left--;
      push          = 1'b1;
      req_in_char   = ch;
      req_last_char = fin;
      chars_sent++;
      n = accept_count;
      do @(negedge clock); while (accept_count == n);
   endtask

   task automatic send_str(input string s, input logic fin);
      for (int i = 0; i < s.len(); i++)
         send_char(s[i], fin && (i == s.len() - 1));
   endtask

   task automatic send_buf();
      for (int i = 0; i < text_buf.size(); i++)
         send_char(text_buf[i], i == text_buf.size() - 1);
   endtask

   // Whole groups, extreme sextets (0 and 63) and single '=' padding
   task automatic test_whole_groups();
      send_str("TWFu", 1'b1);
      send_str("/+z9AAA=", 1'b1);
   endtask

   // '=' in the third slot with a fourth char that is never looked at,
   // '=' in the second slot, data after a terminated group
   task automatic test_padding();
      send_str("TQ=", 1'b0);
      send_char(8'hFF, 1'b1);
      send_str("A=AA", 1'b1);
      send_str("QQ==QUFB", 1'b1);
   endtask

   // Short strings: bad length on its own and over an invalid char
   task automatic test_bad_length();
      send_str("=", 1'b1);
      send_str("TWF", 1'b1);
   endtask

   // About half well-formed strings with random content, the rest damaged
   task automatic test_random_strings();
      int groups;
      int kind;
      int damage;
      int pos;
      while (chars_sent < RANDOM_CHARS + 40) begin
         text_buf.delete();
         groups = $urandom_range(0, 3);
         kind   = $urandom_range(0, 2);
         repeat (groups * 4) text_buf.push_back(b64_alphabet[$urandom_range(0, 63)]);
         repeat (4 - kind) text_buf.push_back(b64_alphabet[$urandom_range(0, 63)]);
         repeat (kind) text_buf.push_back(b64d_pkg::PAD_CHAR);

         damage = $urandom_range(0, 9);
         case (damage)
            0: begin   // any raw byte in any place
               pos = $urandom_range(0, text_buf.size() - 1);
               text_buf[pos] = 8'($urandom_range(0, 255));
            end
            1: begin   // truncated
               repeat ($urandom_range(1, 3))
                  if (text_buf.size() > 1) void'(text_buf.pop_back());
            end
            2: begin   // stray tail
               repeat ($urandom_range(1, 3))
                  text_buf.push_back($urandom_range(0, 1) ? 8'($urandom_range(0, 255))
                                     : b64_alphabet[$urandom_range(0, 63)]);
            end
            3: begin   // '=' dropped in anywhere
               pos = $urandom_range(0, text_buf.size());
               text_buf.insert(pos, b64d_pkg::PAD_CHAR);
            end
            4: begin   // another group after the last one
               repeat (4) text_buf.push_back(b64_alphabet[$urandom_range(0, 63)]);
            end
            default: ;
         endcase
         send_buf();
      end
   endtask

   initial begin
      for (int i = 0; i < 256; i++) begin
         sextet_tab[i]  = 6'd0;
         in_alphabet[i] = 1'b0;
      end
      for (int i = 0; i < 64; i++) begin
         sextet_tab[b64_alphabet[i]]  = 6'(i);
         in_alphabet[b64_alphabet[i]] = 1'b1;
      end
      slot_pos       = b64d_pkg::SLOT_FIRST;
      held           = 6'd0;
      term_seen      = 1'b0;
      pad_third      = 1'b0;
      err_code       = b64d_pkg::STAT_OK;
      accept_count   = 0;
      chars_sent     = 0;
      mismatch_count = 0;
      cycle_count    = 0;
      burst_left     = 0;
      stall_mode     = 0;
      pop_tick       = 0;
      reset          = 1'b1;
      push           = 1'b0;
      pop            = 1'b0;
      req_in_char    = 8'h00;
      req_last_char  = 1'b0;

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_whole_groups();
      test_padding();
      test_bad_length();
      test_random_strings();

      push = 1'b0;
      while (owed_words.size() != 0) @(negedge clock);
      // catch any stray word after the last expected one
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (mismatch_count == 0 && owed_words.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

[files.f]
sv/b64d_pkg.sv
sv/b64d_front.sv
sv/b64d_back.sv
sv/base64_stream_decoder.sv
verif/base64_stream_decoder_tb.sv
